// File: design/ntws_pkg.sv
// ---------------------------------------------------------------------------
// ntws_pkg
// Shared constants for the nearest-to-target window select block.
// ---------------------------------------------------------------------------
`default_nettype none

package ntws_pkg;

    // Default window depth and sample width (signed Q8.8 by default)
    localparam int DEF_WINDOW_SIZE  = 10;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Width of the samples_held result field
    localparam int HELD_W = 4;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int TOL_W      = 8;

    // Register index of change_tolerance and its reset value (2 sample LSBs, about 0.008 degree in Q8.8)
    localparam logic REG_CHANGE_TOL = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd2;

endpackage

`default_nettype wire

// File: design/ntws_cfg.sv
// ---------------------------------------------------------------------------
// ntws_cfg
// APB register file holding the target change tolerance.
// ---------------------------------------------------------------------------
`default_nettype none

module ntws_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ntws_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ntws_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ntws_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [ntws_pkg::TOL_W-1:0]      tolerance
);
    import ntws_pkg::*;

    logic             reg_sel;
    logic             wr_en;
    logic [TOL_W-1:0] tol_reg;
    logic [TOL_W-1:0] tol_next;

    // Word index sits at paddr[2]; only index 0 exists
    assign reg_sel = (paddr[2] == REG_CHANGE_TOL);
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready & reg_sel;

    always_comb
    begin
        tol_next = tol_reg;
        if (wr_en)
        begin
            tol_next = pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = APB_DATA_W'(tol_reg);
        end
    end

    assign tolerance = tol_reg;

endmodule

`default_nettype wire

// File: design/nearest_to_target_window_select.sv
// ---------------------------------------------------------------------------
// nearest_to_target_window_select
// Keeps a ring window of recent temperature samples and returns the held
// sample closest to the target; bypasses and clears on a non-positive target.
// ---------------------------------------------------------------------------
//
//  Channel | Dir | Transaction
//  --------+-----+-------------------------------------------------------------
//  s_*     | in  | tdata = measured, target (signed, SAMPLE_WIDTH each)
//  m_*     | out | tdata = shown_value (SAMPLE_WIDTH), samples_held (4)
//  APB     | in  | change_tolerance at byte address 0
//
//  An item is accepted, then takes one window memory read per held sample
//  (1 to WINDOW_SIZE), then finishes the compare in ST_LAST and loads the
//  output register in ST_RESULT. A bypass item goes straight to ST_RESULT.
//  The single read port of the window memory sets the scan length.
//  Reset clears all control state; window contents need none.
//  A result waiting on m_tready holds the block in its result step.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_to_target_window_select #(
    parameter int WINDOW_SIZE  = ntws_pkg::DEF_WINDOW_SIZE,
    parameter int SAMPLE_WIDTH = ntws_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // APB configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ntws_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [ntws_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [ntws_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: measured, target (from bit 0 up), zero padded to bytes
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // Output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata: shown_value, samples_held (from bit 0 up), zero padded to bytes
    output logic [((SAMPLE_WIDTH+ntws_pkg::HELD_W+7)/8)*8-1:0] m_tdata
);
    import ntws_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int OUT_W  = ((SW + HELD_W + 7) / 8) * 8;
    localparam int ADDR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    // Absolute distance of two samples, one bit wider than a sample
    function automatic logic [SW:0] abs_dist(input logic signed [SW-1:0] a,
                                             input logic signed [SW-1:0] b);
        logic signed [SW:0] d;
        begin
            d = {a[SW-1], a} - {b[SW-1], b};
            abs_dist = d[SW] ? (SW+1)'(-d) : (SW+1)'(d);
        end
    endfunction

    // Configuration register
    logic [TOL_W-1:0] tolerance;

    ntws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tolerance (tolerance)
    );

    // Control state
    state_t                 state_reg,   state_next;
    logic [ADDR_W-1:0]      slot_reg,    slot_next;
    logic [CNT_W-1:0]       fill_reg,    fill_next;
    logic                   latched_reg, latched_next;
    logic signed [SW-1:0]   last_tgt_reg, last_tgt_next;
    logic [ADDR_W-1:0]      rd_addr_reg, rd_addr_next;
    logic                   rd_vld_reg,  rd_vld_next;
    logic                   rd_first_reg, rd_first_next;
    logic                   out_vld_reg, out_vld_next;

    // Datapath registers
    logic signed [SW-1:0]   tgt_reg;
    logic signed [SW-1:0]   rd_data_reg;
    logic signed [SW-1:0]   best_val_reg;
    logic [SW:0]            best_err_reg;
    logic signed [SW-1:0]   out_val_reg;
    logic [HELD_W-1:0]      out_held_reg;

    // Window memory
    logic signed [SW-1:0]   window_mem [WINDOW_SIZE];

    // Input decode
    logic                   accept;
    logic signed [SW-1:0]   in_meas;
    logic signed [SW-1:0]   in_tgt;
    logic                   bypass;
    logic                   clear_win;
    logic [ADDR_W-1:0]      eff_slot;
    logic [CNT_W-1:0]       eff_fill;
    logic                   mem_wr;
    logic                   out_load;
    logic [SW:0]            scan_err;
    logic                   scan_take;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign in_meas  = s_tdata[SW-1:0];
    assign in_tgt   = s_tdata[2*SW-1:SW];
    assign bypass   = in_tgt[SW-1] | (in_tgt == '0);

    // New or moved target restarts the window
    assign clear_win = !latched_reg ||
                       (abs_dist(in_tgt, last_tgt_reg) > (SW+1)'(tolerance));
    assign eff_slot  = clear_win ? '0 : slot_reg;
    assign eff_fill  = clear_win ? '0 : fill_reg;
    assign mem_wr    = accept & ~bypass;

    assign out_load  = (state_reg == ST_RESULT) && (!out_vld_reg || m_tready);

    // Compare stage on the registered read data
    assign scan_err  = abs_dist(rd_data_reg, tgt_reg);
    assign scan_take = rd_vld_reg && (rd_first_reg || (scan_err < best_err_reg));

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        latched_next  = latched_reg;
        last_tgt_next = last_tgt_reg;
        rd_addr_next  = rd_addr_reg;
        rd_vld_next   = 1'b0;
        rd_first_next = 1'b0;
        out_vld_next  = out_vld_reg;

        if (m_tvalid && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bypass)
                    begin
                        slot_next     = '0;
                        fill_next     = '0;
                        latched_next  = 1'b0;
                        last_tgt_next = '0;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        if (clear_win)
                        begin
                            latched_next  = 1'b1;
                            last_tgt_next = in_tgt;
                        end
                        slot_next = (eff_slot == ADDR_W'(WINDOW_SIZE - 1)) ?
                                    '0 : eff_slot + ADDR_W'(1);
                        fill_next = (eff_fill < CNT_W'(WINDOW_SIZE)) ?
                                    eff_fill + CNT_W'(1) : eff_fill;
                        rd_addr_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // One read per cycle over the held slots
                rd_vld_next   = 1'b1;
                rd_first_next = (rd_addr_reg == '0);
                if ((CNT_W'(rd_addr_reg) + CNT_W'(1)) == fill_reg)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + ADDR_W'(1);
                end
            end
            ST_LAST:
            begin
                // Last read data is compared this cycle
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            fill_reg     <= '0;
            latched_reg  <= 1'b0;
            last_tgt_reg <= '0;
            rd_addr_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            latched_reg  <= latched_next;
            last_tgt_reg <= last_tgt_next;
            rd_addr_reg  <= rd_addr_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Window memory: write at accept, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            window_mem[eff_slot] <= in_meas;
        end
        rd_data_reg <= window_mem[rd_addr_reg];
    end

    // Datapath: target capture, running best, output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tgt_reg <= in_tgt;
            if (bypass)
            begin
                best_val_reg <= in_meas;
            end
        end
        if (scan_take)
        begin
            best_val_reg <= rd_data_reg;
            best_err_reg <= scan_err;
        end
        if (out_load)
        begin
            out_val_reg  <= best_val_reg;
            out_held_reg <= HELD_W'(fill_reg);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'({out_held_reg, out_val_reg});

    // Checks
    ast_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_SIZE))
        else $error("fill count exceeds window size");

    ast_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !rd_vld_reg)
        else $error("read data pending while idle");

    ast_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_RESULT))
        else $error("result loaded outside result step");

    ast_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !bypass) |=> (state_reg == ST_SCAN) && (fill_reg != '0))
        else $error("window item did not start a scan");

endmodule

`default_nettype wire
